FILE: hw/rtl/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 hash block.
package sha256_pkg;

   localparam int unsigned FifoDepth = 4;

   localparam logic [31:0] INITIAL_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Command from front end to back end
   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_FINAL = 2'd1,
      CMD_BOTH  = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_ROUND    = 3'd1,
      ST_FOLD     = 3'd2,
      ST_PAD      = 3'd3,
      ST_EMIT     = 3'd4
   } state_type;

   // What follows the compression in progress
   typedef enum logic [1:0] {
      FIN_NONE = 2'd0,
      FIN_PAD  = 2'd1,
      FIN_EMIT = 2'd2,
      FIN_LEN  = 2'd3
   } fin_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

FILE: hw/rtl/sha256_message_hash.sv
// Top level of the SHA-256 hash block: input queue and compression core.
// A transaction is written into the registered input queue before the core can take it.
// A full block then runs 64 rounds and a fold; each padding block runs pad, 64 rounds, fold.
// After the last fold the 8 digest words go out one a cycle while rsp_pop is held.
// Inside a block one byte is packed a cycle while the queue holds items; none in rounds or fold.
// Reset is synchronous and active high; it empties the queues and restores the IV.
module sha256_message_hash #(
   parameter int unsigned FIFO_DEPTH = sha256_pkg::FifoDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_last_word
);
   import sha256_pkg::*;

   logic     q_valid, q_take;
   item_type q_item;

   sha256_front #(.DEPTH(FIFO_DEPTH)) u_front (
      .clock, .reset, .req_push, .req_full, .req_data_byte, .req_has_byte,
      .req_end_of_message, .q_valid, .q_item, .q_take
   );

   sha256_core u_core (
      .clock, .reset, .q_valid, .q_item, .q_take, .rsp_empty, .rsp_pop,
      .rsp_digest_word, .rsp_last_word
   );
endmodule

FILE: hw/rtl/sha256_front.sv
// Front end: classifies input transactions and queues them for the core.
module sha256_front #(
   parameter int unsigned DEPTH = sha256_pkg::FifoDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_has_byte,
   input  logic                 req_end_of_message,
   output logic                 q_valid,
   output sha256_pkg::item_type q_item,
   input  logic                 q_take
);
   import sha256_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type         mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             push_ok, useful, take_ok;
   item_type         new_item;

   assign req_full = (count_ff == (AW+1)'(DEPTH));
   assign push_ok  = req_push && !req_full;
   // items with neither byte nor end mark do nothing and are dropped here
   assign useful   = req_has_byte || req_end_of_message;
   assign take_ok  = q_take && q_valid;
   assign q_valid  = (count_ff != '0);
   assign q_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      new_item.data = req_data_byte;
      if (req_has_byte && req_end_of_message) begin
         new_item.cmd = CMD_BOTH;
      end else if (req_end_of_message) begin
         new_item.cmd = CMD_FINAL;
      end else begin
         new_item.cmd = CMD_BYTE;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && useful) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (AW+1)'(push_ok && useful) - (AW+1)'(take_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok && useful) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH)) else $error("queue count overflow");
   a_no_take_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !take_ok) else $error("take from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push_ok && useful && !take_ok) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("count did not advance");
endmodule

FILE: hw/rtl/sha256_core.sv
// Back end: block packing, padding, 64-round compression and digest output queue.
module sha256_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  sha256_pkg::item_type q_item,
   output logic                 q_take,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [31:0]          rsp_digest_word,
   output logic                 rsp_last_word
);
   import sha256_pkg::*;

   state_type     state_ff, state_in;
   logic [31:0]   h_ff [8];
   logic [31:0]   v_ff [8];
   logic [31:0]   w_ff [16];
   logic [31:0]   pad_words [16];
   logic [5:0]    bcnt_ff, bcnt_in;
   logic [63:0]   len_ff, len_in;
   logic [5:0]    rnd_ff, rnd_in;
   logic [2:0]    oidx_ff, oidx_in;
   // what follows the current compression: nothing, a pad block, a length block, the digest
   fin_type       fin_ff, fin_in;
   logic [31:0]   out_word_ff;
   logic          out_last_ff, out_valid_ff;

   logic [31:0]   wt, t1, t2, wnew;
   logic          load_byte, do_round, do_fold, do_pad, do_emit, out_take;
   logic [3:0]    widx;
   logic [1:0]    bsel;

   assign out_take        = out_valid_ff && rsp_pop;
   assign rsp_empty       = !out_valid_ff;
   assign rsp_digest_word = out_word_ff;
   assign rsp_last_word   = out_last_ff;

   assign wnew = small_s1(w_ff[14]) + w_ff[9] + small_s0(w_ff[1]) + w_ff[0];
   // window is kept as a shift line: w_ff[0] is the current word in rounds 0 to 15, the oldest after
   assign wt = (rnd_ff < 6'd16) ? w_ff[0] : wnew;
   assign t1 = v_ff[7] + big_s1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + ROUND_K[rnd_ff] + wt;
   assign t2 = big_s0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
             ^ (v_ff[1] & v_ff[2]));
   assign widx = bcnt_ff[5:2];
   assign bsel = bcnt_ff[1:0];

   // padded block: marker and zeros after the bytes, or all zeros for a length-only block
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         pad_words[i] = w_ff[i];
         for (int b = 0; b < 4; b++) begin
            if (fin_ff == FIN_LEN || 6'(i * 4 + b) > bcnt_ff) begin
               pad_words[i][31 - 8*b -: 8] = 8'h00;
            end else if (6'(i * 4 + b) == bcnt_ff) begin
               pad_words[i][31 - 8*b -: 8] = PAD_BYTE;
            end
         end
      end
      if (fin_ff == FIN_LEN || bcnt_ff < 6'd56) begin
         pad_words[14] = len_ff[63:32];
         pad_words[15] = len_ff[31:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      bcnt_in   = bcnt_ff;
      len_in    = len_ff;
      rnd_in    = rnd_ff;
      oidx_in   = oidx_ff;
      fin_in    = fin_ff;
      q_take    = 1'b0;
      load_byte = 1'b0;
      do_round  = 1'b0;
      do_fold   = 1'b0;
      do_pad    = 1'b0;
      do_emit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               if (q_item.cmd == CMD_FINAL) begin
                  state_in = ST_PAD;
                  fin_in   = FIN_NONE;
               end else begin
                  load_byte = 1'b1;
                  bcnt_in   = bcnt_ff + 1'b1;
                  len_in    = len_ff + 64'd8;
                  if (q_item.cmd == CMD_BOTH) begin
                     fin_in = FIN_PAD;
                  end else begin
                     fin_in = FIN_NONE;
                  end
                  if (bcnt_ff == 6'd63) begin
                     state_in = ST_ROUND;
                     rnd_in   = '0;
                  end else if (q_item.cmd == CMD_BOTH) begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_PAD: begin
            // marker byte, zeros, and length if it fits
            do_pad   = 1'b1;
            state_in = ST_ROUND;
            rnd_in   = '0;
            if (fin_ff == FIN_LEN || bcnt_ff < 6'd56) begin
               fin_in = FIN_EMIT;
            end else begin
               fin_in = FIN_LEN;
            end
            bcnt_in  = '0;
         end
         ST_ROUND: begin
            do_round = 1'b1;
            rnd_in   = rnd_ff + 1'b1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            do_fold = 1'b1;
            if (fin_ff == FIN_EMIT) begin
               state_in = ST_EMIT;
               oidx_in  = '0;
            end else if (fin_ff == FIN_PAD || fin_ff == FIN_LEN) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || out_take) begin
               do_emit = 1'b1;
               oidx_in = oidx_ff + 1'b1;
               if (oidx_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  fin_in   = FIN_NONE;
                  len_in   = '0;
                  bcnt_in  = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bcnt_ff      <= '0;
         len_ff       <= '0;
         rnd_ff       <= '0;
         oidx_ff      <= '0;
         fin_ff       <= FIN_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bcnt_ff  <= bcnt_in;
         len_ff   <= len_in;
         rnd_ff   <= rnd_in;
         oidx_ff  <= oidx_in;
         fin_ff   <= fin_in;
         if (do_emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // chain value resets to IV; reloaded when the last digest word enters the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= INITIAL_HASH[i];
      end else if (do_fold) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end else if (do_emit && oidx_ff == 3'd7) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= INITIAL_HASH[i];
      end
   end

   always_ff @(posedge clock) begin
      if (do_emit) begin
         out_word_ff <= h_ff[oidx_ff];
         out_last_ff <= (oidx_ff == 3'd7);
      end
   end

   always_ff @(posedge clock) begin
      if (load_byte) begin
         case (bsel)
            2'd0: w_ff[widx][31:24] <= q_item.data;
            2'd1: w_ff[widx][23:16] <= q_item.data;
            2'd2: w_ff[widx][15:8]  <= q_item.data;
            default: w_ff[widx][7:0] <= q_item.data;
         endcase
         if (bcnt_ff == 6'd63) begin
            for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
         end
      end else if (do_pad) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= pad_words[i];
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (do_round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wt;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> state_ff == ST_IDLE) else $error("take outside idle");
   a_emit_last: assert property (@(posedge clock) disable iff (reset)
      (do_emit && oidx_ff == 3'd7) |=> rsp_last_word && !rsp_empty)
      else $error("last word missing");
   a_round_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == 6'd63) |=> state_ff == ST_FOLD)
      else $error("round counter out of step");
endmodule

FILE: verif/sha256_message_hash_checker.sv
// Checker for the SHA-256 hash block: watches both queues, hashes bytes and compares digests.
`timescale 1ns / 1ps
module sha256_message_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [31:0] rsp_digest_word,
   input  logic        rsp_last_word,
   output int          fail_count,
   output int          pending_count
);
   import sha256_pkg::INITIAL_HASH;
   import sha256_pkg::ROUND_K;
   import sha256_pkg::PAD_BYTE;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } digest_entry;

   logic [31:0] chain [8];
   logic [31:0] block_words [16];
   logic [5:0]  fill_count;
   logic [63:0] bit_length;
   digest_entry expect_mem [4096];
   int          wr_idx;
   int          rd_idx;

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic put_byte(int pos, logic [7:0] b);
      int sh;
      sh = 24 - 8 * (pos % 4);
      block_words[pos / 4] = (block_words[pos / 4] & ~(32'hff << sh)) | ({24'd0, b} << sh);
   endtask

   task automatic compress_block();
      logic [31:0] v [8];
      logic [31:0] w [16];
      logic [31:0] t1, t2, s0, s1, x;
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 16; i++) w[i] = block_words[i];
      for (int t = 0; t < 64; t++) begin
         if (t >= 16) begin
            x = w[(t - 15) % 16];
            s0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
            x = w[(t - 2) % 16];
            s1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
            w[t % 16] = s1 + w[(t - 7) % 16] + s0 + w[t % 16];
         end
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t % 16];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
   endtask

   task automatic absorb_transaction(logic [7:0] b, logic has, logic eom);
      int pos;
      if (has) begin
         put_byte(fill_count, b);
         bit_length = bit_length + 64'd8;
         if (fill_count == 6'd63) begin
            compress_block();
            fill_count = '0;
         end else begin
            fill_count = fill_count + 6'd1;
         end
      end
      if (eom) begin
         pos = fill_count;
         put_byte(pos, PAD_BYTE);
         for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
         if (pos >= 56) begin
            compress_block();
            for (int i = 0; i < 16; i++) block_words[i] = '0;
         end
         block_words[14] = bit_length[63:32];
         block_words[15] = bit_length[31:0];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            expect_mem[wr_idx].word = chain[i];
            expect_mem[wr_idx].last = (i == 7);
            wr_idx++;
         end
         for (int i = 0; i < 8; i++) chain[i] = INITIAL_HASH[i];
         fill_count = '0;
         bit_length = '0;
      end
   endtask

   assign pending_count = wr_idx - rd_idx;

   always @(posedge clock) begin
      digest_entry exp_word;
      if (reset) begin
         fill_count = '0;
         bit_length = '0;
         wr_idx = 0;
         rd_idx = 0;
         for (int i = 0; i < 8; i++) chain[i] = INITIAL_HASH[i];
         for (int i = 0; i < 16; i++) block_words[i] = '0;
      end else begin
         if (req_push && !req_full)
            absorb_transaction(req_data_byte, req_has_byte, req_end_of_message);
         if (rsp_pop && !rsp_empty) begin
            if (rd_idx == wr_idx) begin
               $error("unexpected digest word %h", rsp_digest_word);
               fail_count++;
            end else begin
               exp_word = expect_mem[rd_idx];
               rd_idx++;
               if (rsp_digest_word !== exp_word.word) begin
                  $error("digest_word expected %h actual %h", exp_word.word, rsp_digest_word);
                  fail_count++;
               end
               if (rsp_last_word !== exp_word.last) begin
                  $error("last_word expected %b actual %b", exp_word.last, rsp_last_word);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

FILE: verif/tb_top.sv
// Top of the SHA-256 hash block testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [7:0]  req_data_byte = 0;
   logic        req_has_byte = 0;
   logic        req_end_of_message = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [31:0] rsp_digest_word;
   logic        rsp_last_word;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct = 35;
   int          recv_idle_pct = 47;
   int          hold_cycles = 0;
   int          cycle_count = 0;
   bit          stall_req = 0;
   bit          stall_seen = 0;

   localparam int CycleLimit = 400000;

   sha256_message_hash DUT (.*);
   sha256_message_hash_checker checker_i (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random pops, or one long hold-off once requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_pop <= 0;
      end else if (stall_req && !stall_seen) begin
         stall_seen <= 1;
         hold_cycles <= 600;
         rsp_pop <= 0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // called and returning at a falling edge; full only moves at rising edges
   task automatic send_transaction(logic [7:0] b, logic has, logic eom);
      bit accepted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 0;
         @(negedge clock);
      end
      req_push <= 1;
      req_data_byte <= b;
      req_has_byte <= has;
      req_end_of_message <= eom;
      do begin
         accepted = !req_full;
         @(negedge clock);
      end while (!accepted);
   endtask

   task automatic send_message(int len, logic eom_carries_byte);
      int body;
      body = (eom_carries_byte && len > 0) ? len - 1 : len;
      for (int i = 0; i < body; i++) begin
         if ($urandom_range(9) == 0) send_transaction(8'($urandom), 1'b0, 1'b0);
         send_transaction(8'($urandom), 1'b1, 1'b0);
      end
      if (eom_carries_byte && len > 0) send_transaction(8'($urandom), 1'b1, 1'b1);
      else send_transaction(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic random_messages(int n);
      int len;
      for (int m = 0; m < n; m++) begin
         case ($urandom_range(2))
            0: len = $urandom_range(3);
            1: len = $urandom_range(4, 12);
            default: len = $urandom_range(13, 24);
         endcase
         send_message(len, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: empty message, extreme bytes, idle transactions, padding edges
      send_transaction(8'h00, 1'b0, 1'b1);
      send_transaction(8'hff, 1'b0, 1'b0);
      send_transaction(8'h00, 1'b1, 1'b0);
      send_transaction(8'hff, 1'b1, 1'b0);
      send_transaction(8'hff, 1'b0, 1'b0);
      send_transaction(8'h5a, 1'b1, 1'b1);
      send_message(3, 1'b1);
      send_message(56, 1'b0);
      send_message(64, 1'b1);
      // long receiver stall while the sender keeps pushing
      stall_req = 1;
      send_message(2, 1'b1);
      send_message(1, 1'b1);
      send_message(0, 1'b0);
      send_message(5, 1'b1);
      random_messages(2);
      send_idle_pct = 47;
      recv_idle_pct = 35;
      random_messages(2);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_messages(2);
      req_push <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
